@@ src/fcvw_pkg.sv @@
// Shared constants, command and status types for the valid-window FIR correlator.
package fcvw_pkg;

  localparam int MAX_TAPS    = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int PTR_W       = $clog2(MAX_TAPS);
  localparam int CNT_W       = PTR_W + 1;
  localparam int MODE_W      = 2;
  localparam int INDEX_W     = 8;
  localparam int TAPCFG_W    = 9;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int SUM_W       = 40;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_PUSH,
    CMD_RESTART
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                op;
    logic [INDEX_W-1:0]     tap_index;
    logic [SAMPLE_BITS-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } bk_state_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] fill;
  } bk_status_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  // Zero taps behaves as one, anything above the store depth as the full depth.
  function automatic logic [CNT_W-1:0] taps_in_use(input logic [TAPCFG_W-1:0] cfg);
    logic [CNT_W-1:0] t;
    if (cfg == '0) begin
      t = CNT_W'(1);
    end else if (int'(cfg) > MAX_TAPS) begin
      t = CNT_W'(MAX_TAPS);
    end else begin
      t = CNT_W'(cfg);
    end
    return t;
  endfunction

endpackage

@@ src/fcvw_front.sv @@
// Input side: accepts beats, decodes the mode and drops beats that do nothing.
module fcvw_front import fcvw_pkg::*; (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [MODE_W-1:0]         mode,
  input  logic [INDEX_W-1:0]        tap_index,
  input  logic signed [SAMPLE_BITS-1:0] value,
  input  q_status_t                 q_stat,
  output logic                      q_push,
  output cmd_t                      q_din
);

  logic accept;
  logic keep;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    keep            = 1'b0;
    q_din.op        = CMD_PUSH;
    q_din.tap_index = tap_index;
    q_din.value     = value;
    case (mode)
      MODE_LOAD: begin
        q_din.op = CMD_LOAD;
        keep     = int'(tap_index) < MAX_TAPS;
      end
      MODE_PUSH: begin
        q_din.op = CMD_PUSH;
        keep     = 1'b1;
      end
      MODE_RESTART: begin
        q_din.op = CMD_RESTART;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = accept && keep;

endmodule

@@ src/fcvw_queue.sv @@
// Short command queue between the front and the multiply-accumulate engine.
module fcvw_queue import fcvw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      din,
  input  logic      pop,
  output cmd_t      dout,
  output q_status_t stat
);

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign stat.empty = count == '0;
  assign stat.count = count;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = entry[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= tail + QPTR_W'(1);
      end
      if (do_pop) begin
        head <= head + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[tail] <= din;
    end
  end

endmodule

@@ src/fcvw_back.sv @@
// Engine: coefficient and sample memories, shared multiply-accumulate, result register.
module fcvw_back import fcvw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [TAPCFG_W-1:0]   tap_count,
  input  cmd_t                  cmd,
  input  q_status_t             q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [SUM_W-1:0] window_sum,
  output bk_status_t            stat
);

  logic [SAMPLE_BITS-1:0] ring_mem [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]    coef_valid;

  bk_state_t        state, state_next;
  logic [PTR_W-1:0] wp, wp_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [CNT_W-1:0] kcnt, kcnt_next;
  logic [PTR_W-1:0] base, base_next;
  logic [CNT_W-1:0] taps;
  logic [CNT_W-1:0] fill_inc;
  logic [PTR_W-1:0] ring_rd;
  logic             issue;
  logic             ring_we;
  logic             coef_we;
  logic             acc_clear;
  logic             out_load;

  logic [SAMPLE_BITS-1:0]    ring_q;
  logic [SAMPLE_BITS-1:0]    coef_q;
  logic                      coef_ok;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   acc;
  logic                      v1;
  logic                      v2;

  assign taps     = taps_in_use(tap_count);
  assign fill_inc = (int'(fill) < MAX_TAPS) ? fill + CNT_W'(1) : fill;
  assign ring_rd  = base + kcnt[PTR_W-1:0];
  assign out_load = (state == BK_DRAIN) && !v1 && !v2 && (!out_valid || !out_stall);

  assign stat.busy = state != BK_IDLE;
  assign stat.fill = fill;

  always_comb begin
    state_next = state;
    wp_next    = wp;
    fill_next  = fill;
    kcnt_next  = kcnt;
    base_next  = base;
    pop        = 1'b0;
    issue      = 1'b0;
    ring_we    = 1'b0;
    coef_we    = 1'b0;
    acc_clear  = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (cmd.op)
            CMD_LOAD: begin
              coef_we = 1'b1;
            end
            CMD_RESTART: begin
              fill_next = '0;
            end
            CMD_PUSH: begin
              ring_we   = 1'b1;
              wp_next   = wp + PTR_W'(1);
              fill_next = fill_inc;
              if (fill_inc >= taps) begin
                // Window start wraps modulo the ring depth.
                base_next  = wp_next - taps[PTR_W-1:0];
                kcnt_next  = '0;
                acc_clear  = 1'b1;
                state_next = BK_RUN;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      BK_RUN: begin
        issue     = 1'b1;
        kcnt_next = kcnt + CNT_W'(1);
        if (kcnt == taps - CNT_W'(1)) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (out_load) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      wp         <= '0;
      fill       <= '0;
      kcnt       <= '0;
      base       <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      out_valid  <= 1'b0;
      coef_valid <= '0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      fill  <= fill_next;
      kcnt  <= kcnt_next;
      base  <= base_next;
      v1    <= issue;
      v2    <= v1;
      if (coef_we) begin
        coef_valid[cmd.tap_index[PTR_W-1:0]] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp] <= cmd.value;
    end
    ring_q <= ring_mem[ring_rd];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[cmd.tap_index[PTR_W-1:0]] <= cmd.value;
    end
    coef_q  <= coef_mem[kcnt[PTR_W-1:0]];
    coef_ok <= coef_valid[kcnt[PTR_W-1:0]];
  end

  // Never-loaded taps read as zero.
  always_ff @(posedge clk) begin
    prod <= $signed(ring_q) * $signed(coef_ok ? coef_q : '0);
    if (acc_clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (out_load) begin
      window_sum <= acc;
    end
  end

endmodule

@@ src/fir_convolution_valid_window.sv @@
// Path of a window push: queue, run state, drain state, result register, out_valid.
// One multiply-accumulate per tap on the shared unit; no pop until the result register loads.
// Coefficient loads, restarts and pushes that fill no window are done in the idle state.
// Reset (rst, synchronous): taps = 1, all coefficients read as zero, stream empty.
// There is no clearing pass: coefficient valid bits clear together on reset.
module fir_convolution_valid_window import fcvw_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [MODE_W-1:0]             mode,
  input  logic [INDEX_W-1:0]            tap_index,
  input  logic signed [SAMPLE_BITS-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SUM_W-1:0]       window_sum,
  input  logic                          cfg_wr_en,
  input  logic [TAPCFG_W-1:0]           cfg_wr_data
);

  logic [TAPCFG_W-1:0] tap_count;
  q_status_t           q_stat;
  bk_status_t          bk_stat;
  cmd_t                q_din;
  cmd_t                q_dout;
  logic                q_push;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAPCFG_W'(1);
    end else if (cfg_wr_en) begin
      tap_count <= cfg_wr_data;
    end
  end

  fcvw_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .tap_index (tap_index),
    .value     (value),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  fcvw_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  fcvw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tap_count  (tap_count),
    .cmd        (q_dout),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .window_sum (window_sum),
    .stat       (bk_stat)
  );

`ifndef NO_ASSERTIONS
  a_result_from_engine: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(bk_stat.busy))
    else $error("result appeared without a finished accumulation");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(bk_stat.fill) <= MAX_TAPS)
    else $error("fill count beyond ring depth");

  a_queue_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(q_stat.count) <= QUEUE_DEPTH && (in_stall == q_stat.full))
    else $error("command queue overrun");
`endif

endmodule
